// ===== rtl/famh_pkg.sv =====
// ============================================================================
// famh_pkg: shared types and constants for the 4-ary min-heap insert block
// Branching factor, status and operation codes, FSM states, control structs.
// ============================================================================
package famh_pkg;

    // Branching factor is fixed at 4; parent index is a decrement and a shift.
    localparam int ARITY_LOG2   = 2;
    localparam int ARITY        = 1 << ARITY_LOG2;
    localparam int CAPACITY_DEF = 64;
    localparam int KEY_W        = 32;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_READ   = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_NOT_FILLED = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SIFT,
        S_RDWAIT,
        S_DONE
    } state_t;

    // Controller -> datapath
    typedef struct packed {
        logic accept;   // latch item, issue first store read
        logic sift;     // one sift-up step (compare, write, next read)
        logic capture;  // take read data as the read result
        logic emit;     // load the output register
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic full;
        logic idx_ok;
        logic sift_done;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/famh_ctrl.sv =====
// ============================================================================
// famh_ctrl: sequencing FSM for the heap block
// Steps each item through accept, sift-up or read wait, and result hand-off.
// ============================================================================
module famh_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  famh_pkg::op_t    op,
    input  famh_pkg::sts_t   sts,
    output logic             s_tready,
    output famh_pkg::cmd_t   cmd
);

    famh_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= famh_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            famh_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (op == famh_pkg::OP_INSERT) begin
                        state_next = sts.full ? famh_pkg::S_DONE : famh_pkg::S_SIFT;
                    end else begin
                        state_next = sts.idx_ok ? famh_pkg::S_RDWAIT : famh_pkg::S_DONE;
                    end
                end
            end
            famh_pkg::S_SIFT: begin
                cmd.sift = 1'b1;
                if (sts.sift_done) begin
                    state_next = famh_pkg::S_DONE;
                end
            end
            famh_pkg::S_RDWAIT: begin
                cmd.capture = 1'b1;
                state_next  = famh_pkg::S_DONE;
            end
            famh_pkg::S_DONE: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = famh_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = famh_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/famh_datapath.sv =====
// ============================================================================
// famh_datapath: heap store, sift-up hole datapath and result register
// One store write and one registered store read per cycle.
// ============================================================================
module famh_datapath #(
    parameter int CAPACITY = famh_pkg::CAPACITY_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  famh_pkg::cmd_t                     cmd,
    output famh_pkg::sts_t                     sts,
    input  famh_pkg::op_t                      op_in,
    input  logic signed [famh_pkg::KEY_W-1:0]  value_in,
    input  logic [5:0]                         idx_in,
    input  logic                               m_tready,
    output logic                               m_tvalid,
    output logic [71:0]                        m_tdata,
    output logic [1:0]                         m_tuser
);

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 6) ? CW : 6;

    logic signed [famh_pkg::KEY_W-1:0] mem [CAPACITY];

    logic signed [famh_pkg::KEY_W-1:0] key_reg;
    logic signed [famh_pkg::KEY_W-1:0] rdata_reg;
    logic signed [famh_pkg::KEY_W-1:0] root_reg;
    logic signed [famh_pkg::KEY_W-1:0] rdval_reg;
    logic [AW-1:0]                     pos_reg;
    logic [CW-1:0]                     fill_reg;
    famh_pkg::status_t                 status_reg;
    logic                              m_tvalid_reg;
    logic [71:0]                       m_tdata_reg;
    logic [1:0]                        m_tuser_reg;

    logic                              full;
    logic                              idx_ok;
    logic                              swap;
    logic [AW-1:0]                     pos_par;
    logic [AW-1:0]                     pos_gpar;
    logic [AW-1:0]                     fill_par;
    logic [AW-1:0]                     rd_addr;
    logic signed [famh_pkg::KEY_W-1:0] wdata;
    logic signed [famh_pkg::KEY_W-1:0] min_now;

    assign full     = (fill_reg == CW'(CAPACITY));
    assign idx_ok   = (CMPW'(idx_in) < CMPW'(fill_reg));
    assign pos_par  = (pos_reg - AW'(1)) >> famh_pkg::ARITY_LOG2;
    assign pos_gpar = (pos_par - AW'(1)) >> famh_pkg::ARITY_LOG2;
    assign fill_par = (AW'(fill_reg) - AW'(1)) >> famh_pkg::ARITY_LOG2;

    // Hole moves up while the new key is strictly below the parent
    assign swap  = (pos_reg != '0) && (key_reg < rdata_reg);
    assign wdata = swap ? rdata_reg : key_reg;

    always_comb begin
        if (cmd.accept) begin
            rd_addr = (op_in == famh_pkg::OP_READ) ? AW'(idx_in) : fill_par;
        end else begin
            rd_addr = pos_gpar;
        end
    end

    assign min_now = (fill_reg != '0) ? root_reg : '0;

    assign sts.full      = full;
    assign sts.idx_ok    = idx_ok;
    assign sts.sift_done = !swap;
    assign sts.out_free  = !m_tvalid_reg || m_tready;

    // Store: write and registered read
    always_ff @(posedge aclk) begin
        if (cmd.sift) begin
            mem[pos_reg] <= wdata;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            key_reg   <= value_in;
            pos_reg   <= AW'(fill_reg);
            rdval_reg <= '0;
            if (op_in == famh_pkg::OP_INSERT) begin
                status_reg <= full ? famh_pkg::ST_FULL : famh_pkg::ST_OK;
            end else begin
                status_reg <= idx_ok ? famh_pkg::ST_OK : famh_pkg::ST_NOT_FILLED;
            end
        end
        if (cmd.sift) begin
            if (swap) begin
                pos_reg <= pos_par;
            end
            if (pos_reg == '0) begin
                root_reg <= wdata;
            end
        end
        if (cmd.capture) begin
            rdval_reg <= rdata_reg;
        end
        if (cmd.emit) begin
            m_tdata_reg <= {1'b0, 7'(fill_reg), min_now, rdval_reg};
            m_tuser_reg <= status_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.sift && !swap) begin
                fill_reg <= fill_reg + CW'(1);
            end
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Hole position never runs past the fill count
    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sift |-> (CW'(pos_reg) <= fill_reg))
        else $error("sift position beyond fill count");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(CAPACITY))
        else $error("fill count above capacity");

    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && op_in == famh_pkg::OP_INSERT && full) |=> $stable(fill_reg))
        else $error("insert into full store changed fill count");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_tvalid_reg || m_tready))
        else $error("result loaded over a pending transfer");

endmodule

// ===== rtl/four_ary_min_heap_insert.sv =====
// Path to m_tvalid: accept, then sift steps (insert; the key climbs 0..3 levels at 64
//   entries) or a read wait (read), none if dropped or a bad read; then result load.
// Throughput: one item at a time; the next input transfer is taken the cycle after
//   the result is loaded, even while that result still waits on m_tready.
// The sift-up rate is one tree level per cycle, set by the single store read port.
// Reset (aresetn low, synchronous): fill count and FSM cleared; store not swept.
// ============================================================================
// four_ary_min_heap_insert: 4-ary min-heap with insert and indexed read
// Level-order store; inserts sift up by moving the hole, reads return an entry.
// ============================================================================
module four_ary_min_heap_insert #(
    parameter int CAPACITY = famh_pkg::CAPACITY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] value (signed), [37:32] read_index, rest zero
    input  logic        s_tuser,   // [0] operation: 0 insert, 1 read

    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [31:0] read_value, [63:32] min_value,
                                   // [70:64] entry_count, rest zero
    output logic [1:0]  m_tuser    // [1:0] status: 0 ok, 1 full, 2 not filled
);

    famh_pkg::cmd_t cmd;
    famh_pkg::sts_t sts;
    famh_pkg::op_t  op;

    assign op = famh_pkg::op_t'(s_tuser);

    // FSM: accept -> sift steps or read wait -> result hand-off
    famh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .op       (op),
        .sts      (sts),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    // Store, sift-up compare/write, output register
    famh_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .op_in    (op),
        .value_in ($signed(s_tdata[31:0])),
        .idx_in   (s_tdata[37:32]),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
